>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert with an active-low reset that disables the check
`define AAS_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// assert that is checked during reset as well
`define AAS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/core/aas_pkg.sv
// ----------------------------------------------------------------------------
// aas_pkg
// Types and constants of the alarm annunciator sequencer.
// ----------------------------------------------------------------------------
package aas_pkg;

    localparam int unsigned CHANNELS          = 8;
    localparam int unsigned HALF_SECOND_TICKS = 50;

    localparam logic [7:0]  CH_MASK       = 8'((9'd1 << CHANNELS) - 9'd1);
    localparam logic [5:0]  HALF_TICKS    = 6'(HALF_SECOND_TICKS);
    localparam logic [63:0] PRESETS_RESET = 64'd723401728380766730;

    // configuration register indexes (paddr[4:3])
    localparam logic [1:0] REG_PRESETS   = 2'd0;
    localparam logic [1:0] REG_AUTORESET = 2'd1;
    localparam logic [1:0] REG_TICK_MASK = 2'd2;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    // output tdata field positions
    localparam int unsigned O_LAMP_LSB   = 0;
    localparam int unsigned O_HORN_BIT   = 8;
    localparam int unsigned O_UNACK_LSB  = 9;
    localparam int unsigned O_STATES_LSB = 17;
    localparam int unsigned O_PHASE_BIT  = 33;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_NEW      = 2'd1,
        ST_ACCEPTED = 2'd2
    } t_chan_state;

endpackage

>>> rtl/core/alarm_annunciator_sequencer.sv
// ----------------------------------------------------------------------------
// alarm_annunciator_sequencer
// A scan tick's result is registered and shows in the cycle after it is accepted.
// Throughput: one scan tick per cycle; a stalled result holds off the input.
// All eight channels are resolved by parallel logic in a single pass.
// Reset (synchronous, active low) loads the register defaults, debounce presets
// and divider, clears other channel, horn and timer state; no clear pass needed.
// ----------------------------------------------------------------------------
module alarm_annunciator_sequencer
    import aas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: raw_lines[7:0], ack_alarm[8], silence_horn[9], lamp_test[10], zero pad
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tdata: lamp_mask[7:0], horn_on[8], unacked_mask[16:9],
    //        channel_states[32:17], flash_phase[33], zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    logic [63:0] r_presets;
    logic [7:0]  r_autoreset_cfg;
    logic [7:0]  r_tick_mask;

    logic [7:0]  r_dbc [CHANNELS];
    logic [7:0]  r_deb;
    logic [7:0]  r_unacked;
    t_chan_state r_state [CHANNELS];
    logic        r_horn;
    logic [5:0]  r_div;
    logic [7:0]  r_hs_count;
    logic        r_phase;
    logic [7:0]  r_remaining;
    logic [7:0]  r_last_masked;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [7:0]  n_dbc [CHANNELS];
    logic [7:0]  n_deb;
    logic [7:0]  n_unacked;
    t_chan_state n_state [CHANNELS];
    logic        n_horn;
    logic [5:0]  n_div;
    logic [7:0]  n_hs_count;
    logic        n_phase;
    logic [7:0]  n_remaining;
    logic [7:0]  n_last_masked;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic [7:0]  raw;
    logic        ack;
    logic        silence;
    logic        test;
    logic [7:0]  rise;
    logic [7:0]  dec;
    logic [7:0]  lamps;
    logic [7:0]  masked;
    logic [7:0]  rem_dec;
    logic [15:0] states;
    logic        horn_set;
    logic        horn_quiet;
    logic [5:0]  div_dec;
    logic        accept;
    logic        cfg_wr;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        case (paddr[4:3])
            REG_PRESETS:   prdata = r_presets;
            REG_AUTORESET: prdata = {56'd0, r_autoreset_cfg};
            REG_TICK_MASK: prdata = {56'd0, r_tick_mask};
            default:       prdata = 64'd0;
        endcase
    end

    always_comb begin
        raw     = s_axis_tdata[7:0] & CH_MASK;
        ack     = s_axis_tdata[8];
        silence = s_axis_tdata[9];
        test    = s_axis_tdata[10];

        // debounce
        n_deb = r_deb;
        dec   = 8'd0;
        for (int n = 0; n < CHANNELS; n++) begin
            if (raw[n]) begin
                dec[n]   = (r_dbc[n] == 8'd1);
                n_dbc[n] = r_dbc[n] - 8'd1;
                if (dec[n]) begin
                    n_deb[n] = 1'b1;
                end
            end else begin
                n_dbc[n] = r_presets[8*n +: 8];
                n_deb[n] = 1'b0;
            end
        end
        n_deb    = n_deb & CH_MASK;
        rise     = n_deb & ~r_deb;
        horn_set = r_horn | (rise != 8'd0);

        // half-second divider
        div_dec    = r_div - 6'd1;
        n_div      = div_dec;
        n_hs_count = r_hs_count;
        n_phase    = r_phase;
        if (div_dec == 6'd0) begin
            n_div      = HALF_TICKS;
            n_hs_count = r_hs_count + 8'd1;
            n_phase    = ~r_phase;
        end

        // horn and lamps
        horn_quiet = horn_set & ~silence;
        n_unacked  = (((~horn_quiet & ack) ? 8'd0 : r_unacked) | rise) & CH_MASK;
        lamps      = (n_phase ? n_unacked : 8'd0) | (n_deb & ~n_unacked);
        if (test) begin
            lamps = 8'hFF;
        end
        lamps = lamps & CH_MASK;

        // channel states
        states = 16'd0;
        for (int n = 0; n < CHANNELS; n++) begin
            n_state[n] = rise[n] ? ST_NEW : r_state[n];
            if (ack && n_state[n] == ST_NEW) begin
                n_state[n] = ST_ACCEPTED;
            end
            if (n_state[n] == ST_ACCEPTED && !raw[n]) begin
                n_state[n] = ST_NORMAL;
            end
            states[2*n +: 2] = n_state[n];
        end

        // horn auto-reset
        n_horn        = horn_quiet;
        n_remaining   = r_remaining;
        n_last_masked = r_last_masked;
        masked        = n_hs_count & r_tick_mask;
        rem_dec       = r_remaining - 8'd1;
        if (horn_quiet && r_autoreset_cfg != 8'd0) begin
            n_last_masked = masked;
            if (masked != r_last_masked) begin
                n_remaining = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_horn      = 1'b0;
                    n_remaining = r_autoreset_cfg;
                end
            end
        end

        n_out_data = '0;
        n_out_data[O_LAMP_LSB +: 8]    = lamps;
        n_out_data[O_HORN_BIT]         = n_horn;
        n_out_data[O_UNACK_LSB +: 8]   = n_unacked;
        n_out_data[O_STATES_LSB +: 16] = states;
        n_out_data[O_PHASE_BIT]        = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presets       <= PRESETS_RESET;
            r_autoreset_cfg <= 8'd0;
            r_tick_mask     <= 8'd0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_PRESETS:   r_presets       <= pwdata;
                REG_AUTORESET: r_autoreset_cfg <= pwdata[7:0];
                REG_TICK_MASK: r_tick_mask     <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < CHANNELS; n++) begin
                r_dbc[n]   <= PRESETS_RESET[8*n +: 8];
                r_state[n] <= ST_NORMAL;
            end
            r_deb         <= 8'd0;
            r_unacked     <= 8'd0;
            r_horn        <= 1'b0;
            r_div         <= HALF_TICKS;
            r_hs_count    <= 8'd0;
            r_phase       <= 1'b0;
            r_remaining   <= 8'd0;
            r_last_masked <= 8'd0;
        end else if (accept) begin
            for (int n = 0; n < CHANNELS; n++) begin
                r_dbc[n]   <= n_dbc[n];
                r_state[n] <= n_state[n];
            end
            r_deb         <= n_deb;
            r_unacked     <= n_unacked;
            r_horn        <= n_horn;
            r_div         <= n_div;
            r_hs_count    <= n_hs_count;
            r_phase       <= n_phase;
            r_remaining   <= n_remaining;
            r_last_masked <= n_last_masked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> rtl/core/aas_checker.sv
// ----------------------------------------------------------------------------
// aas_checker
// Port-level checks of the alarm annunciator sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aas_checker
    import aas_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [15:0] out_states;
    logic        in_xfer;
    logic        out_stall;

    assign out_states = m_axis_tdata[O_STATES_LSB +: 16];
    assign in_xfer    = s_axis_tvalid & s_axis_tready;
    assign out_stall  = m_axis_tvalid & ~m_axis_tready;

    `AAS_ASSERT_ALWAYS(a_reset_drops_valid, i_clk, !i_rst_n |=> !m_axis_tvalid)

    `AAS_ASSERT_RST(a_transfer_gives_result, i_clk, i_rst_n, in_xfer |=> m_axis_tvalid)

    `AAS_ASSERT_RST(a_no_state_code3, i_clk, i_rst_n, m_axis_tvalid |-> ((out_states & (out_states >> 1) & 16'h5555) == 16'd0))

    `AAS_ASSERT_RST(a_stall_holds, i_clk, i_rst_n, out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind alarm_annunciator_sequencer aas_checker u_aas_checker (.*);
